>>> hdl/mstw_pkg.sv
// mstw_pkg: sizes, payload structs and weight helper for min_spanning_tree_weight
// no dependencies
package mstw_pkg;

  localparam int MAX_EDGES    = 256;
  localparam int MAX_VERTICES = 256;
  localparam int WEIGHT_BITS  = 16;

  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int CNT_W  = EIDX_W + 1;
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int SUM_W  = 24;

  typedef struct packed {
    logic [7:0]         start_vertex;
    logic [7:0]         end_vertex;
    logic signed [15:0] edge_weight;
    logic               last_edge;
  } in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] total_weight;
    logic [7:0]              tree_edge_count;
    logic                    edges_dropped;
  } out_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] w;
  } edge_t;

  // low WEIGHT_BITS of the raw field, sign extended
  function automatic logic signed [SUM_W-1:0] wext(input logic [15:0] r);
    logic signed [WEIGHT_BITS-1:0] t;
    t = r[WEIGHT_BITS-1:0];
    return SUM_W'(t);
  endfunction

endpackage

>>> hdl/min_spanning_tree_weight.sv
// min_spanning_tree_weight: edge store with insertion sort and kruskal union-find
// depends on mstw_pkg
//
// Edges arrive one transaction at a time and are kept in ascending weight order
// in a single-port-write / single-port-read edge memory: each new edge is
// inserted by walking down from the end, reading each heavier entry and then
// writing it up one slot, until the new edge comes to rest and is written.
// The transaction with last_edge set starts kruskal: every stored edge is read
// once, then each endpoint is walked to its root through the parent memory,
// one read per hop; the merge is written in the cycle that finds the second
// root. The parent memory has a valid flop per entry so that an unwritten vertex
// reads as its own root and the whole table resets at once when a result is
// sent. One result is sent per graph; a new graph may start loading while the
// result is still stalled.
module min_spanning_tree_weight
  import mstw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INS  = 4'd1;
  localparam logic [3:0] S_INW  = 4'd2;
  localparam logic [3:0] S_K0   = 4'd3;
  localparam logic [3:0] S_K1   = 4'd4;
  localparam logic [3:0] S_FA   = 4'd5;
  localparam logic [3:0] S_FB   = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0] st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d;
  logic [EIDX_W-1:0] j_q, j_d;
  logic ovf_q, ovf_d, lst_q, lst_d;
  edge_t new_q, new_d, cur_q, cur_d;
  logic [VIDX_W-1:0] x_q, x_d, ra_q, ra_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [7:0] taken_q, taken_d;
  logic out_v_q, out_v_d;
  out_t out_q, out_d;

  // edge memory
  edge_t emem [MAX_EDGES];
  edge_t e_rd_q;
  logic e_we, e_re;
  logic [EIDX_W-1:0] e_wa, e_ra;
  edge_t e_wd;

  // parent memory
  logic [VIDX_W-1:0] pmem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pv_q;
  logic [VIDX_W-1:0] p_rd_q;
  logic p_rdv_q;
  logic p_we, p_re, p_clr;
  logic [VIDX_W-1:0] p_wa, p_wd, p_ra;
  logic [VIDX_W-1:0] par;

  logic in_acc;
  assign in_stall_o  = (st_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // parent of the vertex read last cycle; unwritten entries point to themselves
  assign par = p_rdv_q ? p_rd_q : x_q;

  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_wa] <= e_wd;
    if (e_re) e_rd_q <= emem[e_ra];
    if (p_we) pmem[p_wa] <= p_wd;
    if (p_re) p_rd_q <= pmem[p_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      p_rdv_q <= 1'b0;
    end else begin
      if (p_re) p_rdv_q <= pv_q[p_ra];
      if (p_clr) pv_q <= '0;
      else if (p_we) pv_q[p_wa] <= 1'b1;
    end
  end

  function automatic logic in_range(input logic [7:0] v);
    return 32'(v) < 32'(MAX_VERTICES);
  endfunction

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; ovf_d = ovf_q; lst_d = lst_q;
    new_d = new_q; cur_d = cur_q; x_d = x_q; ra_d = ra_q; sum_d = sum_q;
    taken_d = taken_q; out_d = out_q;
    out_v_d = out_v_q && out_stall_i;
    e_we = 1'b0; e_re = 1'b0; e_wa = j_q; e_ra = j_q; e_wd = new_q;
    p_we = 1'b0; p_re = 1'b0; p_clr = 1'b0; p_wa = ra_q; p_wd = x_q; p_ra = x_q;

    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          new_d = '{a: in_data_i.start_vertex, b: in_data_i.end_vertex,
                    w: in_data_i.edge_weight};
          lst_d = in_data_i.last_edge;
          i_d   = '0;
          if (32'(cnt_q) < 32'(MAX_EDGES)) begin
            j_d   = cnt_q[EIDX_W-1:0];
            cnt_d = cnt_q + 1'b1;
            st_d  = S_INS;
          end else begin
            ovf_d = 1'b1;
            st_d  = in_data_i.last_edge ? S_K0 : S_IDLE;
          end
        end
      end
      S_INS: begin
        if (j_q == '0) begin
          e_we = 1'b1;
          st_d = lst_q ? S_K0 : S_IDLE;
        end else begin
          e_re = 1'b1;
          e_ra = j_q - 1'b1;
          st_d = S_INW;
        end
      end
      S_INW: begin
        e_we = 1'b1;
        if (wext(e_rd_q.w) > wext(new_q.w)) begin
          // shift heavier edge up one slot
          e_wd = e_rd_q;
          j_d  = j_q - 1'b1;
          st_d = S_INS;
        end else begin
          st_d = lst_q ? S_K0 : S_IDLE;
        end
      end
      S_K0: begin
        if (i_q == cnt_q) begin
          st_d = S_DONE;
        end else begin
          e_re = 1'b1;
          e_ra = i_q[EIDX_W-1:0];
          st_d = S_K1;
        end
      end
      S_K1: begin
        cur_d = e_rd_q;
        if (in_range(e_rd_q.a) && in_range(e_rd_q.b)) begin
          p_re = 1'b1;
          p_ra = VIDX_W'(e_rd_q.a);
          x_d  = VIDX_W'(e_rd_q.a);
          st_d = S_FA;
        end else begin
          i_d  = i_q + 1'b1;
          st_d = S_K0;
        end
      end
      S_FA: begin
        p_re = 1'b1;
        if (par == x_q) begin
          ra_d = x_q;
          p_ra = VIDX_W'(cur_q.b);
          x_d  = VIDX_W'(cur_q.b);
          st_d = S_FB;
        end else begin
          p_ra = par;
          x_d  = par;
        end
      end
      S_FB: begin
        if (par == x_q) begin
          if (ra_q != x_q) begin
            // merge components
            p_we    = 1'b1;
            sum_d   = sum_q + wext(cur_q.w);
            taken_d = taken_q + 1'b1;
          end
          i_d  = i_q + 1'b1;
          st_d = S_K0;
        end else begin
          p_re = 1'b1;
          p_ra = par;
          x_d  = par;
        end
      end
      S_DONE: begin
        if (!out_v_q || !out_stall_i) begin
          out_v_d = 1'b1;
          out_d   = '{total_weight: sum_q, tree_edge_count: taken_q,
                      edges_dropped: ovf_q};
          p_clr   = 1'b1;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          sum_d   = '0;
          taken_d = '0;
          st_d    = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ovf_q   <= 1'b0;
      lst_q   <= 1'b0;
      sum_q   <= '0;
      taken_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ovf_q   <= ovf_d;
      lst_q   <= lst_d;
      sum_q   <= sum_d;
      taken_q <= taken_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    cur_q <= cur_d;
    x_q   <= x_d;
    ra_q  <= ra_d;
    out_q <= out_d;
  end

  // a stored or final transaction always makes the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (32'(cnt_q) < 32'(MAX_EDGES) || in_data_i.last_edge)) |=> in_stall_o)
    else $error("block idle after accept");

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(MAX_EDGES)) else $error("edge count overrun");

  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FA || st_q == S_FB) |-> (32'(i_q) < 32'(cnt_q)))
    else $error("root walk past last edge");

  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE && st_d == S_IDLE) |=> (pv_q == '0 && cnt_q == '0))
    else $error("parent table not cleared after result");

endmodule
